>>> src/wrv_pkg.sv
// ----------------------------------------------------------------------------
// Window regression velocity package
// Field widths, the stored window entry and the divider result shared by the
// window regression velocity modules.
// ----------------------------------------------------------------------------
package wrv_pkg;

	localparam int TIME_W = 32;  // sample timestamp
	localparam int ALT_W  = 28;  // sea-level altitude and pad altitude
	localparam int REL_W  = 29;  // altitude relative to the pad
	localparam int VEL_W  = 21;  // fixed-point velocity

	typedef struct packed {
		logic        [TIME_W-1:0] t;
		logic signed [REL_W-1:0]  y;
	} wrv_entry_t;

	typedef struct packed {
		logic signed [VEL_W-1:0] vel;
		logic                    degen;
	} wrv_result_t;

endpackage

>>> src/window_regression_velocity.sv
// ----------------------------------------------------------------------------
// Window regression velocity
// Least-squares slope of pad-relative altitude over time across a sliding
// window of samples, in m/s as signed fixed point.
// ----------------------------------------------------------------------------
// Each accepted sample is worked through in full before the next one is taken:
// the window memory's two read ports deliver one pair of samples per cycle to
// the multiply-accumulate pipeline, and the divider then produces one quotient
// bit per cycle. A window whose times are all equal skips the division. A finished
// result waits in the output register while the next sample is accepted; if that
// beat is still stalled when the next result is ready, the block holds its input
// stalled until the beat leaves. The window starts out as zero samples at time 0,
// which take part in the fit. The pad altitude may be written at any time the
// block is idle.
module window_regression_velocity #(
	parameter int WINDOW    = 9,
	parameter int FRAC_BITS = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic signed [wrv_pkg::ALT_W-1:0]   pad_altitude_mm,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic        [wrv_pkg::TIME_W-1:0]  time_ms,
	input  logic signed [wrv_pkg::ALT_W-1:0]   altitude_sl_mm,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [wrv_pkg::VEL_W-1:0]   velocity_fixed,
	output logic signed [wrv_pkg::REL_W-1:0]   relative_altitude_mm,
	output logic                               degenerate
);
	import wrv_pkg::*;

	localparam int NPAIRS = WINDOW * (WINDOW - 1) / 2;
	localparam int PAIR_W = $clog2(NPAIRS + 1);
	localparam int IDX_W  = $clog2(WINDOW);
	localparam int DEN_W  = 2 * TIME_W + PAIR_W;
	localparam int NUM_W  = TIME_W + REL_W + PAIR_W + 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PAIRS = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW - 1);
	localparam logic [IDX_W-1:0] IDX_PEN  = IDX_W'(WINDOW - 2);

	logic [2:0]               state_q;
	logic signed [ALT_W-1:0]  pad_q;
	logic [IDX_W-1:0]         wr_ptr_q;
	logic [IDX_W-1:0]         p_q;
	logic [IDX_W-1:0]         q_q;
	logic                     issue_s1;
	logic signed [REL_W-1:0]  rel;
	logic signed [REL_W-1:0]  rel_q;
	logic                     in_acc;
	logic                     pair_rd;
	logic                     div_start;
	logic                     div_done;
	logic                     acc_busy;
	logic                     out_free;
	wrv_entry_t               wr_ent;
	wrv_entry_t               ent_a;
	wrv_entry_t               ent_b;
	wrv_result_t              div_res;
	logic [DEN_W-1:0]         den;
	logic signed [NUM_W-1:0]  num;
	logic                     out_valid_q;
	logic signed [VEL_W-1:0]  vel_q;
	logic signed [REL_W-1:0]  rel_out_q;
	logic                     degen_q;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid & ~in_stall;
	assign pair_rd   = (state_q == ST_PAIRS);
	assign div_start = (state_q == ST_DRAIN) & ~acc_busy;
	assign out_free  = ~out_valid_q | ~out_stall;

	assign rel      = $signed({altitude_sl_mm[ALT_W-1], altitude_sl_mm})
	                - $signed({pad_q[ALT_W-1], pad_q});
	assign wr_ent.t = time_ms;
	assign wr_ent.y = rel;

	wrv_window_mem #(
		.WINDOW (WINDOW),
		.IDX_W  (IDX_W)
	) u_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (in_acc),
		.wr_addr   (wr_ptr_q),
		.wr_data   (wr_ent),
		.rd_en     (pair_rd),
		.rd_addr_a (p_q),
		.rd_addr_b (q_q),
		.rd_data_a (ent_a),
		.rd_data_b (ent_b)
	);

	wrv_pair_sum #(
		.DEN_W (DEN_W),
		.NUM_W (NUM_W)
	) u_pair_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (in_acc),
		.pair_vld (issue_s1),
		.ent_a    (ent_a),
		.ent_b    (ent_b),
		.busy     (acc_busy),
		.den      (den),
		.num      (num)
	);

	wrv_slope_div #(
		.FRAC_BITS (FRAC_BITS),
		.DEN_W     (DEN_W),
		.NUM_W     (NUM_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.den    (den),
		.num    (num),
		.done   (div_done),
		.result (div_res)
	);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rel_q <= rel;
		end
		if ((state_q == ST_OUT) && out_free) begin
			vel_q     <= div_res.vel;
			degen_q   <= div_res.degen;
			rel_out_q <= rel_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pad_q       <= '0;
			wr_ptr_q    <= '0;
			p_q         <= '0;
			q_q         <= '0;
			issue_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			issue_s1 <= pair_rd;
			if (cfg_valid && cfg_ready) begin
				pad_q <= pad_altitude_mm;
			end
			// In ST_OUT a departing beat is replaced by the new one below.
			if (out_valid_q && !out_stall && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						wr_ptr_q <= (wr_ptr_q == IDX_LAST) ? '0 : wr_ptr_q + 1'b1;
						p_q      <= '0;
						q_q      <= IDX_W'(1);
						state_q  <= ST_PAIRS;
					end
				end
				ST_PAIRS: begin
					// Walk every unordered pair once; the sums do not depend on order.
					if (q_q == IDX_LAST) begin
						if (p_q == IDX_PEN) begin
							state_q <= ST_DRAIN;
						end else begin
							p_q <= p_q + 1'b1;
							q_q <= p_q + IDX_W'(2);
						end
					end else begin
						q_q <= q_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (!acc_busy) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid            = out_valid_q;
	assign velocity_fixed       = vel_q;
	assign relative_altitude_mm = rel_out_q;
	assign degenerate           = degen_q;

endmodule

>>> src/wrv_window_mem.sv
// ----------------------------------------------------------------------------
// Window sample memory
// Circular store of the last WINDOW time and altitude pairs with one write
// port and two registered read ports. Entries never written read as zero.
// ----------------------------------------------------------------------------
module wrv_window_mem #(
	parameter int WINDOW = 9,
	parameter int IDX_W  = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [IDX_W-1:0]   wr_addr,
	input  wrv_pkg::wrv_entry_t wr_data,
	input  logic               rd_en,
	input  logic [IDX_W-1:0]   rd_addr_a,
	input  logic [IDX_W-1:0]   rd_addr_b,
	output wrv_pkg::wrv_entry_t rd_data_a,
	output wrv_pkg::wrv_entry_t rd_data_b
);
	import wrv_pkg::*;

	wrv_entry_t        mem [WINDOW];
	logic [WINDOW-1:0] vld_q;
	wrv_entry_t        ent_a_q;
	wrv_entry_t        ent_b_q;
	logic              vld_a_q;
	logic              vld_b_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			ent_a_q <= mem[rd_addr_a];
			ent_b_q <= mem[rd_addr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			vld_a_q <= 1'b0;
			vld_b_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_a_q <= vld_q[rd_addr_a];
				vld_b_q <= vld_q[rd_addr_b];
			end
		end
	end

	// Slots not yet filled since reset stand for samples at time 0, altitude 0.
	assign rd_data_a = vld_a_q ? ent_a_q : '0;
	assign rd_data_b = vld_b_q ? ent_b_q : '0;

endmodule

>>> src/wrv_pair_sum.sv
// ----------------------------------------------------------------------------
// Pairwise sum pipeline
// For each pair of window entries forms (ti-tj)^2 and (ti-tj)*(yi-yj) and
// accumulates them into the exact regression denominator and numerator.
// ----------------------------------------------------------------------------
module wrv_pair_sum #(
	parameter int DEN_W = 70,
	parameter int NUM_W = 68
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     clear,
	input  logic                     pair_vld,
	input  wrv_pkg::wrv_entry_t      ent_a,
	input  wrv_pkg::wrv_entry_t      ent_b,
	output logic                     busy,
	output logic [DEN_W-1:0]         den,
	output logic signed [NUM_W-1:0]  num
);
	import wrv_pkg::*;

	logic signed [TIME_W:0]       dt;
	logic signed [REL_W:0]        dy;
	logic signed [TIME_W:0]       dt_abs;
	logic signed [REL_W:0]        dy_abs;
	logic [TIME_W-1:0]            mt_s2;
	logic [REL_W-1:0]             my_s2;
	logic                         sgn_s2;
	logic                         vld_s2;
	logic [2*TIME_W-1:0]          sq_s3;
	logic [TIME_W+REL_W-1:0]      pr_s3;
	logic                         sgn_s3;
	logic                         vld_s3;
	logic signed [NUM_W-1:0]      pr_ext;
	logic [DEN_W-1:0]             den_q;
	logic signed [NUM_W-1:0]      num_q;

	assign dt     = $signed({1'b0, ent_a.t}) - $signed({1'b0, ent_b.t});
	assign dy     = $signed({ent_a.y[REL_W-1], ent_a.y}) - $signed({ent_b.y[REL_W-1], ent_b.y});
	assign dt_abs = dt[TIME_W] ? -dt : dt;
	assign dy_abs = dy[REL_W] ? -dy : dy;

	always_ff @(posedge clk) begin
		mt_s2  <= dt_abs[TIME_W-1:0];
		my_s2  <= dy_abs[REL_W-1:0];
		sgn_s2 <= dt[TIME_W] ^ dy[REL_W];
		sq_s3  <= mt_s2 * mt_s2;
		pr_s3  <= mt_s2 * my_s2;
		sgn_s3 <= sgn_s2;
	end

	assign pr_ext = $signed(NUM_W'(pr_s3));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			den_q  <= '0;
			num_q  <= '0;
		end else begin
			vld_s2 <= pair_vld;
			vld_s3 <= vld_s2;
			if (clear) begin
				den_q <= '0;
				num_q <= '0;
			end else if (vld_s3) begin
				den_q <= den_q + DEN_W'(sq_s3);
				num_q <= sgn_s3 ? (num_q - pr_ext) : (num_q + pr_ext);
			end
		end
	end

	assign busy = pair_vld | vld_s2 | vld_s3;
	assign den  = den_q;
	assign num  = num_q;

endmodule

>>> src/wrv_slope_div.sv
// ----------------------------------------------------------------------------
// Slope divider
// Restoring division of the rounded, scaled numerator by the denominator,
// one quotient bit per cycle, then saturation; a zero denominator is flagged degenerate.
// ----------------------------------------------------------------------------
module wrv_slope_div #(
	parameter int FRAC_BITS = 8,
	parameter int DEN_W     = 70,
	parameter int NUM_W     = 68
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [DEN_W-1:0]        den,
	input  logic signed [NUM_W-1:0] num,
	output logic                    done,
	output wrv_pkg::wrv_result_t    result
);
	import wrv_pkg::*;

	localparam int Q_W   = VEL_W + 1;
	localparam int A_W   = NUM_W + FRAC_BITS;
	localparam int D_W   = DEN_W + Q_W;
	localparam int DIV_W = ((A_W > D_W) ? A_W : D_W) + 1;
	localparam int CNT_W = $clog2(Q_W);
	localparam logic [Q_W-1:0] POS_MAX = Q_W'((1 << (VEL_W - 1)) - 1);
	localparam logic [Q_W-1:0] NEG_MAX = Q_W'(1 << (VEL_W - 1));

	logic signed [NUM_W-1:0] num_abs;
	logic [DIV_W-1:0]        a_init;
	logic [DIV_W-1:0]        a_q;
	logic [DIV_W-1:0]        ds_q;
	logic [Q_W-1:0]          quo_q;
	logic [Q_W-1:0]          quo_nxt;
	logic [Q_W-1:0]          quo_sat;
	logic [CNT_W-1:0]        cnt_q;
	logic                    run_q;
	logic                    neg_q;
	logic                    done_q;
	logic                    ge;
	wrv_result_t             res_q;

	assign num_abs = num[NUM_W-1] ? -num : num;
	// Adding den before dividing by 2*den rounds half away from zero.
	assign a_init  = (DIV_W'(num_abs[NUM_W-2:0]) << (FRAC_BITS + 1)) + DIV_W'(den);

	assign ge      = (a_q >= ds_q);
	assign quo_nxt = {quo_q[Q_W-2:0], ge};

	always_comb begin
		if (neg_q) begin
			quo_sat = (quo_nxt > NEG_MAX) ? NEG_MAX : quo_nxt;
		end else begin
			quo_sat = (quo_nxt > POS_MAX) ? POS_MAX : quo_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a_init;
			ds_q  <= DIV_W'(den) << Q_W;
			quo_q <= '0;
			neg_q <= num[NUM_W-1];
		end else if (run_q) begin
			if (ge) begin
				a_q <= a_q - ds_q;
			end
			ds_q  <= ds_q >> 1;
			quo_q <= quo_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
			res_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(Q_W - 1);
				if (den == '0) begin
					run_q       <= 1'b0;
					done_q      <= 1'b1;
					res_q.vel   <= '0;
					res_q.degen <= 1'b1;
				end else begin
					run_q <= 1'b1;
				end
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q       <= 1'b0;
					done_q      <= 1'b1;
					res_q.vel   <= neg_q ? -$signed(quo_sat[VEL_W-1:0])
					                     : $signed(quo_sat[VEL_W-1:0]);
					res_q.degen <= 1'b0;
				end
			end
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

>>> tb/window_regression_velocity_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window regression velocity testbench
// Drives timestamped altitude samples and pad altitude writes into the block,
// predicts the least-squares slope of every sample window, and checks each
// result beat against the prediction under random input gaps and output stalls.
// ----------------------------------------------------------------------------
module window_regression_velocity_tb;
	import wrv_pkg::*;

	localparam int WIN         = 9;
	localparam int FRAC        = 8;
	localparam int HOLD_CYCLES = 1500;
	localparam int PHASE_ITEMS = 235;

	localparam logic signed [ALT_W-1:0] ALT_MIN = ALT_W'(-(1 <<< (ALT_W-1)));
	localparam logic signed [ALT_W-1:0] ALT_MAX = ALT_W'((1 << (ALT_W-1)) - 1);
	localparam logic signed [VEL_W-1:0] VEL_MIN = VEL_W'(-(1 <<< (VEL_W-1)));
	localparam logic signed [VEL_W-1:0] VEL_MAX = VEL_W'((1 << (VEL_W-1)) - 1);

	typedef struct packed {
		wrv_result_t             fit;
		logic signed [REL_W-1:0] rel;
	} velocity_result_t;

	logic                     clk             = 1'b0;
	logic                     arst_n          = 1'b0;
	logic                     cfg_valid       = 1'b0;
	logic                     cfg_ready;
	logic signed [ALT_W-1:0]  pad_altitude_mm = '0;
	logic                     in_valid        = 1'b0;
	logic                     in_stall;
	logic        [TIME_W-1:0] time_ms         = '0;
	logic signed [ALT_W-1:0]  altitude_sl_mm  = '0;
	logic                     out_valid;
	logic                     out_stall       = 1'b0;
	logic signed [VEL_W-1:0]  velocity_fixed;
	logic signed [REL_W-1:0]  relative_altitude_mm;
	logic                     degenerate;

	// Predicted state of the block.
	logic signed [ALT_W-1:0]  pad_mm = '0;
	logic        [TIME_W-1:0] win_time [WIN] = '{default: '0};
	logic signed [REL_W-1:0]  win_rel  [WIN] = '{default: '0};

	velocity_result_t fit_queue[$];
	int               errors    = 0;
	bit               gaps_on   = 1'b1;
	int               stall_pct = 30;
	bit               hold_req  = 1'b0;
	int               hold_left = 0;
	int               stall_left = 0;

	window_regression_velocity #(
		.WINDOW    (WIN),
		.FRAC_BITS (FRAC)
	) dut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg_valid            (cfg_valid),
		.cfg_ready            (cfg_ready),
		.pad_altitude_mm      (pad_altitude_mm),
		.in_valid             (in_valid),
		.in_stall             (in_stall),
		.time_ms              (time_ms),
		.altitude_sl_mm       (altitude_sl_mm),
		.out_valid            (out_valid),
		.out_stall            (out_stall),
		.velocity_fixed       (velocity_fixed),
		.relative_altitude_mm (relative_altitude_mm),
		.degenerate           (degenerate)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shifts one sample into the window and fits the slope over all pairs:
	// N*sumT2 - sumT^2 and N*sumTY - sumT*sumY are summed pairwise, exactly.
	function automatic velocity_result_t predict_velocity(input logic [TIME_W-1:0] t,
			input logic signed [ALT_W-1:0] alt);
		velocity_result_t        res;
		logic signed [REL_W-1:0] rel;
		logic signed [TIME_W+1:0] dt;
		logic signed [REL_W+1:0] dy;
		logic signed [127:0]     num;
		logic signed [127:0]     den;
		logic        [127:0]     mag;
		logic        [127:0]     dividend;
		logic        [127:0]     divisor;
		logic        [127:0]     quot;
		rel = alt - pad_mm;
		for (int i = WIN - 1; i > 0; i--) begin
			win_time[i] = win_time[i-1];
			win_rel[i]  = win_rel[i-1];
		end
		win_time[0] = t;
		win_rel[0]  = rel;
		num = '0;
		den = '0;
		for (int i = 0; i < WIN; i++) begin
			for (int j = i + 1; j < WIN; j++) begin
				dt  = $signed({2'b00, win_time[i]}) - $signed({2'b00, win_time[j]});
				dy  = win_rel[i] - win_rel[j];
				den = den + dt * dt;
				num = num + dt * dy;
			end
		end
		res.rel = rel;
		if (den == 0) begin
			res.fit.vel   = '0;
			res.fit.degen = 1'b1;
		end else begin
			// Round half away from zero: floor((2*|num|*2^F + den) / (2*den)).
			mag      = (num < 0) ? -num : num;
			dividend = (mag << (FRAC + 1)) + den;
			divisor  = den << 1;
			quot     = dividend / divisor;
			res.fit.degen = 1'b0;
			if (num < 0) begin
				if (quot >= (128'd1 << (VEL_W - 1)))
					res.fit.vel = VEL_MIN;
				else
					res.fit.vel = -$signed(quot[VEL_W-1:0]);
			end else begin
				if (quot >= (128'd1 << (VEL_W - 1)))
					res.fit.vel = VEL_MAX;
				else
					res.fit.vel = quot[VEL_W-1:0];
			end
		end
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		if (!gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 4);
		if (r < 98)
			return $urandom_range(5, 30);
		return $urandom_range(40, 150);
	endfunction

	function automatic logic signed [ALT_W-1:0] clamp_alt(input int v);
		if (v < int'(ALT_MIN))
			return ALT_MIN;
		if (v > int'(ALT_MAX))
			return ALT_MAX;
		return v[ALT_W-1:0];
	endfunction

	// Valid is left high after the beat; the next send or drain() settles it.
	task automatic send_sample(input logic [TIME_W-1:0] t, input logic signed [ALT_W-1:0] alt);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		time_ms        <= t;
		altitude_sl_mm <= alt;
		do @(posedge clk); while (in_stall);
		fit_queue.push_back(predict_velocity(t, alt));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (fit_queue.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_pad(input logic signed [ALT_W-1:0] v);
		cfg_valid       <= 1'b1;
		pad_altitude_mm <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		pad_mm = v;
	endtask

	// Output side: random short stalls, rare long ones, and a long hold on request.
	always @(posedge clk) begin
		int r;
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (stall_pct == 0) begin
			out_stall <= 1'b0;
		end else begin
			r = $urandom_range(0, 999);
			if (r < 4)
				stall_left = $urandom_range(20, 200);
			out_stall <= (r < 4) || (r < stall_pct * 10);
		end
	end

	always @(posedge clk) begin : check_results
		velocity_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (fit_queue.size() == 0) begin
				$error("result beat with no sample waiting: velocity_fixed %0d", velocity_fixed);
				errors++;
			end else begin
				want = fit_queue.pop_front();
				if (velocity_fixed !== want.fit.vel) begin
					$error("velocity_fixed: expected %0d, actual %0d",
						want.fit.vel, velocity_fixed);
					errors++;
				end
				if (relative_altitude_mm !== want.rel) begin
					$error("relative_altitude_mm: expected %0d, actual %0d",
						want.rel, relative_altitude_mm);
					errors++;
				end
				if (degenerate !== want.fit.degen) begin
					$error("degenerate: expected %0d, actual %0d",
						want.fit.degen, degenerate);
					errors++;
				end
			end
		end
	end

	// The reset window holds zero samples at time 0, so the first samples at time 0
	// leave every time equal. Then the slope is driven past both rails and the
	// timestamp runs across the counter wrap.
	task automatic test_fill_and_saturation();
		send_sample(32'd0, '0);
		send_sample(32'd0, ALT_MAX);
		send_sample(32'd1, ALT_MIN);
		send_sample(32'd2, ALT_MAX);
		send_sample(32'hFFFF_FFFF, ALT_MAX);
		send_sample(32'd0, ALT_MIN);
		drain();
	endtask

	task automatic test_pad_extremes();
		write_pad(ALT_MIN);
		send_sample(32'd5, ALT_MAX);
		drain();
		write_pad(ALT_MAX);
		send_sample(32'd6, ALT_MIN);
		drain();
	endtask

	// Eight equal samples and one 1024 ms later, 2 mm apart, give a slope of
	// exactly half an LSB, which must round away from zero in both signs.
	task automatic test_rounding_ties();
		write_pad('0);
		repeat (8) send_sample(32'd1000, '0);
		send_sample(32'd2024, 28'sd2);
		repeat (8) send_sample(32'd1000, '0);
		send_sample(32'd2024, -28'sd2);
		drain();
	endtask

	// The receiver holds off while samples keep coming, so the block backs up.
	task automatic test_output_hold();
		gaps_on  = 1'b0;
		hold_req = 1'b1;
		for (int i = 0; i < 24; i++)
			send_sample(32'd50_000 + i * 20, clamp_alt(i * 4000));
		drain();
		gaps_on = 1'b1;
	endtask

	task automatic run_flight(input int count);
		int                      sent;
		int                      kind;
		int                      burst;
		int                      dt;
		int                      rate;
		int                      alt_mm;
		logic        [TIME_W-1:0] now_ms;
		logic signed [ALT_W-1:0]  raw_alt;
		sent   = 0;
		rate   = int'($urandom_range(0, 600)) - 300;
		alt_mm = int'($urandom_range(0, 2_000_000)) - 1_000_000;
		now_ms = $urandom_range(0, 100_000);
		while (sent < count) begin
			kind = $urandom_range(0, 99);
			if (kind < 72) begin
				dt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 40);
				now_ms = now_ms + dt;
				if ($urandom_range(0, 19) == 0)
					rate = int'($urandom_range(0, 600)) - 300;
				alt_mm = int'(clamp_alt(alt_mm + rate * dt + int'($urandom_range(0, 200)) - 100));
				send_sample(now_ms, alt_mm[ALT_W-1:0]);
				sent++;
			end else if (kind < 82) begin
				// Stuck clock: a full window at one time makes the fit degenerate.
				burst = $urandom_range(9, 12);
				repeat (burst)
					send_sample(now_ms, clamp_alt(alt_mm + int'($urandom_range(0, 2000)) - 1000));
				sent += burst;
			end else if (kind < 92) begin
				raw_alt = ALT_W'($urandom());
				send_sample($urandom(), raw_alt);
				sent++;
			end else begin
				now_ms  = 32'hFFFF_FFFF - $urandom_range(0, 300);
				raw_alt = ALT_W'($urandom());
				alt_mm  = int'(raw_alt);
				send_sample(now_ms, raw_alt);
				sent++;
			end
		end
	endtask

	task automatic test_random_flight();
		logic signed [ALT_W-1:0] pad_v;
		for (int ph = 0; ph < 8; ph++) begin
			drain();
			case (ph)
				0: pad_v = '0;
				1: pad_v = ALT_MIN;
				2: pad_v = ALT_MAX;
				default: begin
					if (ph % 2 == 0)
						pad_v = ALT_W'($urandom());
					else
						pad_v = ALT_W'($urandom_range(0, 3_000_000));
				end
			endcase
			write_pad(pad_v);
			gaps_on   = (ph % 3) != 0;
			stall_pct = (ph % 4 == 0) ? 0 : 20 * (ph % 4);
			run_flight(PHASE_ITEMS);
		end
		drain();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_and_saturation();
		test_pad_extremes();
		test_rounding_ties();
		test_output_hold();
		test_random_flight();
		drain();
		repeat (200) @(posedge clk);
		if (errors == 0 && fit_queue.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

>>> sim.f
src/wrv_pkg.sv
src/wrv_window_mem.sv
src/wrv_pair_sum.sv
src/wrv_slope_div.sv
src/window_regression_velocity.sv
tb/window_regression_velocity_tb.sv
